[hdl/bfq_pkg.sv]
// Shared types, stage counts and step functions for the quartic bond force core.
// No dependencies; imported by the core, bfq_sqrt, bfq_div and the testbench.
package bfq_pkg;

    localparam int SQRT_STAGES = 8;
    localparam int SQRT_STEPS  = 32 / SQRT_STAGES;
    localparam int DIV_STAGES  = 12;
    localparam int DIV_STEPS   = 48 / DIV_STAGES;
    localparam int DIV_LAT     = DIV_STAGES + 1;
    localparam int PIPE_DEPTH  = 11 + SQRT_STAGES + DIV_LAT;

    localparam logic [47:0] POS_MAX48 = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_MAG48 = 48'h8000_0000_0000;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] root;
        logic [63:0] x;
    } sqrt_state_t;

    typedef struct packed {
        logic [42:0] rem;
        logic [47:0] q;
        logic [47:0] lo;
        logic [42:0] den;
        logic        ovf;
    } div_state_t;

    typedef struct packed {
        logic        ovf;
        logic [47:0] q;
    } div_res_t;

    typedef struct packed {
        logic [47:0] force_x;
        logic [47:0] force_y;
        logic [47:0] force_z;
        logic [47:0] energy;
        logic        active;
    } bond_res_t;

    // One radix-4 digit of the integer square root.
    function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
        logic [34:0] cur;
        logic [34:0] trial;
        sqrt_state_t r;
        cur   = {s.rem, s.x[63:62]};
        trial = {1'b0, s.root, 2'b01};
        r     = s;
        r.x   = {s.x[61:0], 2'b00};
        if (cur >= trial) begin
            r.rem  = 33'(cur - trial);
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.rem  = cur[32:0];
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    // One restoring division step: one quotient bit.
    function automatic div_state_t div_step(div_state_t s);
        logic [43:0] cur;
        div_state_t r;
        cur  = {s.rem, s.lo[47]};
        r    = s;
        r.lo = {s.lo[46:0], 1'b0};
        if (cur >= {1'b0, s.den}) begin
            r.rem = 43'(cur - {1'b0, s.den});
            r.q   = {s.q[46:0], 1'b1};
        end else begin
            r.rem = cur[42:0];
            r.q   = {s.q[46:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[hdl/one_sided_quartic_bond_force_core.sv]
// One-sided quartic bond force core, fully pipelined.
// Stages: 3 input/square, 8 square-root, 8 power/product and 13 divider stages, then
// an output register. Throughput: one item per cycle while the skid entry is empty; a
// two-entry output buffer (register + skid) lets the pipeline keep taking items while
// a result waits. Synchronous active-low reset clears the pipeline and buffer valid
// bits; datapath registers and buffer payloads are not reset.
module one_sided_quartic_bond_force_core
    import bfq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_disp_x,
    input  logic [31:0] s_disp_y,
    input  logic [31:0] s_disp_z,
    input  logic [31:0] s_bond_k,
    input  logic [30:0] s_rest_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_force_x,
    output logic [47:0] m_force_y,
    output logic [47:0] m_force_z,
    output logic [47:0] m_bond_energy_out,
    output logic        m_active
);
    // Whole pipeline advances unless the skid entry is occupied.
    logic en;
    logic skid_valid_reg;
    logic m_valid_reg;
    bond_res_t m_res_reg;
    bond_res_t skid_res_reg;
    bond_res_t pipe_res;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Valid bits travel with the data.
    logic [PIPE_DEPTH-1:0] v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    // Stage 1: take magnitudes and signs of the displacement.
    logic [31:0] disp [3];
    logic [31:0] mag1_reg [3];
    logic [2:0]  neg1_reg;
    logic [31:0] k1_reg;
    logic [30:0] r01_reg;

    assign disp[0] = s_disp_x;
    assign disp[1] = s_disp_y;
    assign disp[2] = s_disp_z;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                neg1_reg[c] <= disp[c][31];
                mag1_reg[c] <= disp[c][31] ? (~disp[c] + 32'd1) : disp[c];
            end
            k1_reg  <= s_bond_k;
            r01_reg <= s_rest_length;
        end
    end

    // Stages 2 and 3: squares, then their sum (exact in 64 bits).
    logic [63:0] sq2_reg [3];
    logic [63:0] sum3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                sq2_reg[c] <= mag1_reg[c] * mag1_reg[c];
            end
            sum3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        end
    end

    logic [31:0] dist11;
    bfq_sqrt u_sqrt (.aclk(aclk), .en(en), .x(sum3_reg), .root(dist11));

    // Side data lines, each aligned to where it is next used.
    logic [30:0] r0_11;
    logic [31:0] k15;
    logic [95:0] mag17_flat;
    logic [2:0]  neg32;

    bfq_delay #(.W(31), .N(2 + SQRT_STAGES)) u_dly_r0 (
        .aclk(aclk), .en(en), .d(r01_reg), .q(r0_11));
    bfq_delay #(.W(32), .N(6 + SQRT_STAGES)) u_dly_k (
        .aclk(aclk), .en(en), .d(k1_reg), .q(k15));
    bfq_delay #(.W(96), .N(8 + SQRT_STAGES)) u_dly_mag (
        .aclk(aclk), .en(en), .d({mag1_reg[2], mag1_reg[1], mag1_reg[0]}), .q(mag17_flat));
    bfq_delay #(.W(3), .N(10 + SQRT_STAGES + DIV_LAT)) u_dly_neg (
        .aclk(aclk), .en(en), .d(neg1_reg), .q(neg32));

    // Stage 12: compare against rest length and form diff.
    logic        act12_reg;
    logic [31:0] diff12_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            act12_reg  <= dist11 > {1'b0, r0_11};
            diff12_reg <= dist11 - {1'b0, r0_11};
        end
    end

    // Stages 13 to 17: diff^2, diff^3 in two partials, diff^4 in three; K*d3 alongside.
    logic [63:0]  p2_13_reg;
    logic [31:0]  diff13_reg, diff14_reg, diff15_reg;
    logic [63:0]  p3lo14_reg, p3hi14_reg;
    logic [95:0]  p3_15_reg;
    logic [63:0]  p4a16_reg, p4b16_reg, p4c16_reg;
    logic [63:0]  kd3a16_reg;
    logic [47:0]  kd3b16_reg;
    logic [31:0]  k16_reg, k17_reg;
    logic [127:0] p4_17_reg;
    logic [79:0]  kd3_17_reg;
    logic [47:0]  d3_15;

    assign d3_15 = p3_15_reg[95:48];

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_13_reg  <= diff12_reg * diff12_reg;
            diff13_reg <= diff12_reg;

            p3lo14_reg <= p2_13_reg[31:0] * diff13_reg;
            p3hi14_reg <= p2_13_reg[63:32] * diff13_reg;
            diff14_reg <= diff13_reg;

            p3_15_reg  <= 96'(p3lo14_reg) + {p3hi14_reg, 32'b0};
            diff15_reg <= diff14_reg;

            p4a16_reg  <= p3_15_reg[31:0] * diff15_reg;
            p4b16_reg  <= p3_15_reg[63:32] * diff15_reg;
            p4c16_reg  <= p3_15_reg[95:64] * diff15_reg;
            kd3a16_reg <= k15 * d3_15[31:0];
            kd3b16_reg <= k15 * d3_15[47:32];
            k16_reg    <= k15;

            p4_17_reg  <= 128'(p4a16_reg) + 128'({p4b16_reg, 32'b0}) + {p4c16_reg, 64'b0};
            kd3_17_reg <= 80'(kd3a16_reg) + {kd3b16_reg, 32'b0};
            k17_reg    <= k16_reg;
        end
    end

    // Stages 18 and 19: K*d4 and the force numerators K*d3*|v|.
    logic [55:0]  d4_17;
    logic [31:0]  mag17 [3];
    logic [63:0]  kd4a18_reg;
    logic [55:0]  kd4b18_reg;
    logic [63:0]  na18_reg [3];
    logic [63:0]  nb18_reg [3];
    logic [47:0]  nc18_reg [3];
    logic [87:0]  kd4_19_reg;
    logic [111:0] num19_reg [3];

    assign d4_17    = p4_17_reg[127:72];
    assign mag17[0] = mag17_flat[31:0];
    assign mag17[1] = mag17_flat[63:32];
    assign mag17[2] = mag17_flat[95:64];

    always_ff @(posedge aclk) begin
        if (en) begin
            kd4a18_reg <= k17_reg * d4_17[31:0];
            kd4b18_reg <= k17_reg * d4_17[55:32];
            for (int c = 0; c < 3; c++) begin
                na18_reg[c] <= kd3_17_reg[31:0] * mag17[c];
                nb18_reg[c] <= kd3_17_reg[63:32] * mag17[c];
                nc18_reg[c] <= kd3_17_reg[79:64] * mag17[c];
            end
            kd4_19_reg <= 88'(kd4a18_reg) + {kd4b18_reg, 32'b0};
            for (int c = 0; c < 3; c++) begin
                num19_reg[c] <= 112'(na18_reg[c]) + 112'({nb18_reg[c], 32'b0})
                              + {nc18_reg[c], 64'b0};
            end
        end
    end

    // Stage 20: halve and saturate the energy, then hold it for the dividers.
    logic [47:0] energy20_reg;
    logic [47:0] energy32;
    always_ff @(posedge aclk) begin
        if (en) begin
            energy20_reg <= (|kd4_19_reg[87:61]) ? '1 : kd4_19_reg[60:13];
        end
    end
    bfq_delay #(.W(48), .N(DIV_STAGES)) u_dly_energy (
        .aclk(aclk), .en(en), .d(energy20_reg), .q(energy32));

    logic        act32;
    logic [31:0] dist19;
    bfq_delay #(.W(1), .N(7 + DIV_LAT)) u_dly_act (
        .aclk(aclk), .en(en), .d(act12_reg), .q(act32));
    bfq_delay #(.W(32), .N(8)) u_dly_dist (
        .aclk(aclk), .en(en), .d(dist11), .q(dist19));

    // Stages 20 to 32: one divider per axis.
    div_res_t    dres [3];
    logic [47:0] force_c [3];
    for (genvar c = 0; c < 3; c++) begin : g_axis
        bfq_div u_div (
            .aclk(aclk), .en(en), .num(num19_reg[c]), .dist_in(dist19), .res(dres[c]));

        // Force opposes the displacement; saturate each sign at its own bound.
        always_comb begin
            logic [47:0] m;
            m = '0;
            if (neg32[c]) begin
                force_c[c] = (dres[c].ovf || dres[c].q > POS_MAX48) ? POS_MAX48 : dres[c].q;
            end else begin
                m = (dres[c].ovf || dres[c].q > NEG_MAG48) ? NEG_MAG48 : dres[c].q;
                force_c[c] = ~m + 48'd1;
            end
        end
    end

    // Drop everything to zero when the bond is not stretched.
    always_comb begin
        pipe_res.force_x = act32 ? force_c[0] : '0;
        pipe_res.force_y = act32 ? force_c[1] : '0;
        pipe_res.force_z = act32 ? force_c[2] : '0;
        pipe_res.energy  = act32 ? energy32 : '0;
        pipe_res.active  = act32;
    end

    // Output register with a skid entry behind it.
    logic pipe_out;
    assign pipe_out = v_reg[PIPE_DEPTH-1] && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (pipe_out) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                m_res_reg <= skid_res_reg;
            end
        end else if (pipe_out) begin
            if (!m_valid_reg || m_ready) begin
                m_res_reg <= pipe_res;
            end else begin
                skid_res_reg <= pipe_res;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_force_x         = m_res_reg.force_x;
    assign m_force_y         = m_res_reg.force_y;
    assign m_force_z         = m_res_reg.force_z;
    assign m_bond_energy_out = m_res_reg.energy;
    assign m_active          = m_res_reg.active;
endmodule

[hdl/bfq_delay.sv]
// Enable-gated shift line that carries side data alongside the pipeline.
// No dependencies.
module bfq_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] tap_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < N; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[N-1];
endmodule

[hdl/bfq_sqrt.sv]
// Pipelined 64-bit integer square root, several radix-4 digits per stage.
// Depends on bfq_pkg.
module bfq_sqrt
    import bfq_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] x,
    output logic [31:0] root
);
    sqrt_state_t stage_reg [SQRT_STAGES];

    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
        sqrt_state_t st_in;
        sqrt_state_t stage_next;
        if (i == 0) begin : g_first
            assign st_in = '{rem: '0, root: '0, x: x};
        end else begin : g_rest
            assign st_in = stage_reg[i-1];
        end
        always_comb begin
            stage_next = st_in;
            for (int j = 0; j < SQRT_STEPS; j++) begin
                stage_next = sqrt_step(stage_next);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[i] <= stage_next;
            end
        end
    end

    assign root = stage_reg[SQRT_STAGES-1].root;
endmodule

[hdl/bfq_div.sv]
// Pipelined restoring divider: 112-bit numerator by (dist << 11), 48-bit quotient
// with an overflow flag. Depends on bfq_pkg.
module bfq_div
    import bfq_pkg::*;
(
    input  logic         aclk,
    input  logic         en,
    input  logic [111:0] num,
    input  logic [31:0]  dist_in,
    output div_res_t     res
);
    div_state_t init_reg;
    div_state_t init_next;
    div_state_t stage_reg [DIV_STAGES];

    always_comb begin
        init_next.den = {dist_in, 11'b0};
        init_next.ovf = num[111:48] >= {21'b0, init_next.den};
        init_next.rem = num[90:48];
        init_next.q   = '0;
        init_next.lo  = num[47:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            init_reg <= init_next;
        end
    end

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        div_state_t st_in;
        div_state_t stage_next;
        if (i == 0) begin : g_first
            assign st_in = init_reg;
        end else begin : g_rest
            assign st_in = stage_reg[i-1];
        end
        always_comb begin
            stage_next = st_in;
            for (int j = 0; j < DIV_STEPS; j++) begin
                stage_next = div_step(stage_next);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[i] <= stage_next;
            end
        end
    end

    assign res.ovf = stage_reg[DIV_STAGES-1].ovf;
    assign res.q   = stage_reg[DIV_STAGES-1].q;
endmodule

[hdl/bfq_checker.sv]
// Port-level checks for the quartic bond force core, bound to the top level.
// Depends on one_sided_quartic_bond_force_core.
module bfq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [31:0] s_disp_x,
    input logic [31:0] s_disp_y,
    input logic [31:0] s_disp_z,
    input logic [31:0] s_bond_k,
    input logic [30:0] s_rest_length,
    input logic        m_valid,
    input logic        m_ready,
    input logic [47:0] m_force_x,
    input logic [47:0] m_force_y,
    input logic [47:0] m_force_z,
    input logic [47:0] m_bond_energy_out,
    input logic        m_active
);
    // A stalled result item stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item withdrawn while stalled");

    // A stalled result item keeps its payload.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_force_x) && $stable(m_force_y)
            && $stable(m_force_z) && $stable(m_bond_energy_out) && $stable(m_active))
        else $error("result payload changed while stalled");

    // Input back-pressure only follows a stalled output.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> $past(m_valid && !m_ready))
        else $error("input stalled without output back-pressure");

    // An unstretched bond gives all-zero results.
    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_active |-> m_force_x == '0 && m_force_y == '0
            && m_force_z == '0 && m_bond_energy_out == '0)
        else $error("inactive bond with non-zero result");
endmodule

bind one_sided_quartic_bond_force_core bfq_checker u_bfq_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench for the one-sided quartic bond force core.
// Depends on bfq_pkg (force saturation bounds) and one_sided_quartic_bond_force_core.
`timescale 1ns / 1ps
module tb_top;
    import bfq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 300;

    // One expected bond result
    typedef struct {
        logic [47:0] fx;
        logic [47:0] fy;
        logic [47:0] fz;
        logic [47:0] energy;
        logic        active;
    } bond_force_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_disp_x;
    logic [31:0] s_disp_y;
    logic [31:0] s_disp_z;
    logic [31:0] s_bond_k;
    logic [30:0] s_rest_length;
    logic        m_valid;
    logic        m_ready;
    logic [47:0] m_force_x;
    logic [47:0] m_force_y;
    logic [47:0] m_force_z;
    logic [47:0] m_bond_energy_out;
    logic        m_active;

    bond_force_t pending_forces[$];
    int          mismatches;
    int          idle_cycles;
    bit          hold_request;
    int          hold_left;
    int          stall_phase;

    one_sided_quartic_bond_force_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_disp_x          (s_disp_x),
        .s_disp_y          (s_disp_y),
        .s_disp_z          (s_disp_z),
        .s_bond_k          (s_bond_k),
        .s_rest_length     (s_rest_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_force_x         (m_force_x),
        .m_force_y         (m_force_y),
        .m_force_z         (m_force_z),
        .m_bond_energy_out (m_bond_energy_out),
        .m_active          (m_active)
    );

    always #10 aclk = ~aclk;

    // Bitwise integer square root, floor of the true root.
    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Force component from |v_c|; sign is opposite to the displacement.
    function automatic logic [47:0] force_component(logic [127:0] kd3, logic [31:0] v,
                                                     logic [63:0] dist_val);
        logic          neg;
        logic [127:0]  mag;
        logic [127:0]  quot;
        logic [47:0]   clipped;
        neg  = v[31];
        mag  = neg ? (128'd1 << 32) - {96'd0, v} : {96'd0, v};
        quot = (kd3 * mag) / ({64'd0, dist_val} << 11);
        if (neg) begin
            return (quot > {80'd0, POS_MAX48}) ? POS_MAX48 : quot[47:0];
        end
        clipped = (quot > {80'd0, NEG_MAG48}) ? NEG_MAG48 : quot[47:0];
        return -clipped;
    endfunction

    // Work out the result of one bond item.
    function automatic bond_force_t quartic_bond_force(logic [31:0] dx, logic [31:0] dy,
                                                        logic [31:0] dz, logic [31:0] k,
                                                        logic [30:0] r0);
        bond_force_t  res;
        logic [63:0]  mx;
        logic [63:0]  my;
        logic [63:0]  mz;
        logic [63:0]  dist_val;
        logic [127:0] diff;
        logic [127:0] cube;
        logic [127:0] quart;
        logic [127:0] d3;
        logic [127:0] d4;
        logic [127:0] en;
        mx = dx[31] ? (64'd1 << 32) - {32'd0, dx} : {32'd0, dx};
        my = dy[31] ? (64'd1 << 32) - {32'd0, dy} : {32'd0, dy};
        mz = dz[31] ? (64'd1 << 32) - {32'd0, dz} : {32'd0, dz};
        dist_val = floor_sqrt(mx * mx + my * my + mz * mz);
        res = '{default: '0};
        if (dist_val <= {33'd0, r0}) return res;
        diff  = {64'd0, dist_val - {33'd0, r0}};
        cube  = diff * diff * diff;
        quart = cube * diff;
        d3    = cube >> 48;
        d4    = quart >> 72;
        res.fx = force_component({96'd0, k} * d3, dx, dist_val);
        res.fy = force_component({96'd0, k} * d3, dy, dist_val);
        res.fz = force_component({96'd0, k} * d3, dz, dist_val);
        en = ({96'd0, k} * d4) >> 13;
        res.energy = (en > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : en[47:0];
        res.active = 1'b1;
        return res;
    endfunction

    // Present one item and hold it until the core takes it.
    task automatic send_bond(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                             logic [31:0] k, logic [30:0] r0);
        @(negedge aclk);
        s_disp_x      = dx;
        s_disp_y      = dy;
        s_disp_z      = dz;
        s_bond_k      = k;
        s_rest_length = r0;
        s_valid       = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_forces.push_back(quartic_bond_force(dx, dy, dz, k, r0));
    endtask

    task automatic idle_input(int cycles);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Random displacement component: mostly modest lengths, sometimes full range.
    function automatic logic [31:0] rand_disp();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
            default: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
        endcase
    endfunction

    task automatic send_random_bond();
        logic [31:0] k;
        logic [30:0] r0;
        k  = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 32'h0010_0000));
        case ($urandom_range(0, 3))
            0:       r0 = 31'($urandom);
            1:       r0 = 31'd0;
            default: r0 = 31'($urandom_range(0, 32'h00C0_0000));
        endcase
        send_bond(rand_disp(), rand_disp(), rand_disp(), k, r0);
    endtask

    task automatic test_directed();
        // zero displacement: distance zero, never active
        send_bond(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 31'd0);
        // distance exactly at the rest length
        send_bond(32'h0100_0000, 32'd0, 32'd0, 32'h0000_1000, 31'h0100_0000);
        // distance below the rest length
        send_bond(32'h0080_0000, 32'hFF80_0000, 32'd0, 32'h0000_1000, 31'h0100_0000);
        // beyond the rest length along each axis, and with mixed signs
        send_bond(32'h0200_0000, 32'd0, 32'd0, 32'h0000_1000, 31'h0100_0000);
        send_bond(32'd0, 32'hFE00_0000, 32'd0, 32'h0000_1000, 31'h0100_0000);
        send_bond(32'd0, 32'd0, 32'h0300_0000, 32'h0000_3000, 31'd0);
        send_bond(32'h0100_0000, 32'hFF00_0000, 32'h0100_0000, 32'h0000_1000, 31'd0);
        // most negative components
        send_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 31'd0);
        send_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 31'd0);
        // extreme components: force and energy saturate
        send_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'd0);
        send_bond(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        // largest rest length with largest distance
        send_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_1000, 31'h7FFF_FFFF);
        // zero force constant while active
        send_bond(32'h0300_0000, 32'h0100_0000, 32'hFF00_0000, 32'd0, 31'h0080_0000);
        // tiny excess: results round to zero yet active
        send_bond(32'h0100_0001, 32'd0, 32'd0, 32'h0000_1000, 31'h0100_0000);
        send_bond(32'd1, 32'hFFFF_FFFF, 32'd1, 32'h0000_0001, 31'd0);
        // alternating bit patterns
        send_bond(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA);
        send_bond(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555);
    endtask

    task automatic test_random_stream(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_random_bond();
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_input($urandom_range(0, 8));
        end
        idle_input(0);
    endtask

    // Hold the result side off while items keep coming, so the pipe fills and stalls.
    task automatic test_output_holdoff();
        hold_request = 1'b1;
        for (int i = 0; i < 60; i++) send_random_bond();
        hold_request = 1'b0;
        idle_input(0);
    endtask

    // Receiver: one long hold per request, else alternate between free flow and random stalls.
    always @(negedge aclk) begin
        if (hold_request && hold_left == 0) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        stall_phase = (stall_phase + 1) % 160;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready   = 1'b0;
        end else if (stall_phase < 80) begin
            m_ready = 1'b1;
        end else begin
            m_ready = ($urandom_range(0, 2) != 0);
        end
    end

    // Compare each delivered item with the oldest expectation.
    always @(posedge aclk) begin
        bond_force_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_forces.size() == 0) begin
                $error("unexpected result item");
                mismatches++;
            end else begin
                exp_res = pending_forces.pop_front();
                if (m_force_x !== exp_res.fx) begin
                    $error("force_x expected %h got %h", exp_res.fx, m_force_x);
                    mismatches++;
                end
                if (m_force_y !== exp_res.fy) begin
                    $error("force_y expected %h got %h", exp_res.fy, m_force_y);
                    mismatches++;
                end
                if (m_force_z !== exp_res.fz) begin
                    $error("force_z expected %h got %h", exp_res.fz, m_force_z);
                    mismatches++;
                end
                if (m_bond_energy_out !== exp_res.energy) begin
                    $error("bond_energy_out expected %h got %h", exp_res.energy,
                           m_bond_energy_out);
                    mismatches++;
                end
                if (m_active !== exp_res.active) begin
                    $error("active expected %b got %b", exp_res.active, m_active);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("one_sided_quartic_bond_force_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_disp_x      = '0;
        s_disp_y      = '0;
        s_disp_z      = '0;
        s_bond_k      = '0;
        s_rest_length = '0;
        m_ready       = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        hold_request  = 1'b0;
        hold_left     = 0;
        stall_phase   = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_stream(250);
        test_output_holdoff();
        test_random_stream(250);

        // drain, then allow the pipeline latency for stray items
        while (pending_forces.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("one_sided_quartic_bond_force_core test passed");
        end else begin
            $display("one_sided_quartic_bond_force_core test failed");
        end
        $finish;
    end

endmodule
